// ===== sv/tfsw_pkg.sv =====
// Package with the shared types, widths and constants of the square-wave series block.
package tfsw_pkg;

    localparam int POS_W = 16;
    localparam int HP_W = 15;
    localparam int ORD_W = 7;
    localparam int OUT_W = 16;
    localparam int CFG_W = 15;
    localparam int DEFAULT_MAX_ORDER = 99;

    localparam int PHASE_W = 32;
    localparam int PHASE_SHIFT = 31;
    localparam int DVD_W = POS_W + PHASE_SHIFT;
    localparam int DVR_W = HP_W;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] PHASE_STEPS = STEP_W'(DVD_W);
    localparam int SIN_W = 31;
    localparam logic [STEP_W-1:0] TERM_STEPS = STEP_W'(SIN_W);

    localparam int MUL_W = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_SHIFT = 30;
    localparam int ACC_W = 34;

    localparam int OUT_SHIFT = 46;
    localparam int Q14_W = PROD_W - OUT_SHIFT;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (OUT_SHIFT - 1);
    localparam logic [Q14_W-1:0] POS_LIMIT = Q14_W'(32767);
    localparam logic [Q14_W-1:0] NEG_LIMIT = Q14_W'(32768);
    localparam logic [OUT_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 16'h8000;

    localparam logic [HP_W-1:0] HP_RESET = 15'd4096;
    localparam logic [ORD_W-1:0] ORD_RESET = 7'd1;

    localparam logic [MUL_W-1:0] Q30_ONE = 32'h4000_0000;
    localparam logic [MUL_W-1:0] COEF_A1 = 32'd1686629713;
    localparam logic [MUL_W-1:0] COEF_A3 = 32'd693598669;
    localparam logic [MUL_W-1:0] COEF_A5 = 32'd85569306;
    localparam logic [MUL_W-1:0] COEF_A7 = 32'd5026994;
    localparam logic [MUL_W-1:0] COEF_A9 = 32'd172273;
    localparam logic [MUL_W-1:0] K4PI = 32'd1367130549;

    typedef enum logic {
        REG_HALF_PERIOD = 1'b0,
        REG_SERIES_ORDER = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_TERM,
        ST_SQ,
        ST_P9,
        ST_P7,
        ST_P5,
        ST_P3,
        ST_P1,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCALE,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

// ===== sv/tfsw_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module tfsw_div
    import tfsw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_req_t req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output logic done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVR_W-1:0] rem_reg, rem_next;
    logic [DVR_W-1:0] dvr_reg, dvr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [DVR_W:0] trial;
    logic [DVR_W:0] diff;
    logic fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff = trial - {1'b0, dvr_reg};
        fits = trial >= {1'b0, dvr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvr_next = dvr_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvr_next = divisor;
            cnt_next = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/truncated_fourier_square_wave.sv =====
// Top level of the truncated Fourier square-wave synthesizer.
// A phase division comes first; each odd harmonic then takes its own divide by n.
// A new item is accepted only when busy is low, so the next one waits until the last result is done.
// The done strobe lasts one cycle and wave_value holds until the next result; the receiver cannot stall them.
// Reset returns the sequencer to idle and loads half_period 4096 and series_order 1.
module truncated_fourier_square_wave
    import tfsw_pkg::*;
#(
    parameter int MAX_ORDER = DEFAULT_MAX_ORDER
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [POS_W-1:0] position,
    output logic busy,
    output logic done,
    output logic signed [OUT_W-1:0] wave_value,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int N_W = $clog2(MAX_ORDER + 3);

    state_t state_reg, state_next;
    logic [HP_W-1:0] half_period_reg;
    logic [ORD_W-1:0] series_order_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] ang_reg, ang_next;
    logic [N_W-1:0] n_reg, n_next;
    logic [MUL_W-1:0] t_reg, t_next;
    logic [MUL_W-1:0] t2_reg, t2_next;
    logic neg_reg, neg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic done_reg, done_next;
    logic [OUT_W-1:0] wave_value_reg, wave_value_next;

    logic [MUL_W-1:0] op_a, op_b;
    logic [PROD_W-1:0] mul_res;
    logic [MUL_W-1:0] prod_q30;
    logic [N_W-1:0] order;
    logic [1:0] quad;
    logic [MUL_W-1:0] r_ext;
    logic [ACC_W-1:0] acc_mag;
    logic [ACC_W-1:0] quo_ext;
    logic [PROD_W-1:0] rnd;
    logic [Q14_W-1:0] q14;
    logic [DVR_W-1:0] hp_eff;

    div_req_t div_req;
    logic [DVD_W-1:0] div_dividend;
    logic [DVR_W-1:0] div_divisor;
    logic div_done;
    logic [DVD_W-1:0] div_quo;

    tfsw_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .done(div_done),
        .quotient(div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HP_RESET;
            series_order_reg <= ORD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data[HP_W-1:0];
                REG_SERIES_ORDER: series_order_reg <= cfg_data[ORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign prod_q30 = prod_reg[Q_SHIFT+MUL_W-1:Q_SHIFT];
    assign order = (32'(series_order_reg) > 32'(MAX_ORDER)) ? N_W'(MAX_ORDER)
                                                             : N_W'(series_order_reg);
    assign quad = ang_reg[PHASE_W-1:PHASE_W-2];
    assign r_ext = {2'b00, ang_reg[PHASE_W-3:0]};
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign quo_ext = {{(ACC_W-SIN_W){1'b0}}, div_quo[SIN_W-1:0]};
    assign rnd = prod_reg + ROUND_HALF;
    assign q14 = rnd[PROD_W-1:OUT_SHIFT];
    assign hp_eff = (half_period_reg == '0) ? DVR_W'(1) : half_period_reg;
    assign mul_res = op_a * op_b;

    assign div_dividend = (state_reg == ST_IDLE)
                        ? {position, {(DVD_W-POS_W){1'b0}}}
                        : {prod_q30[SIN_W-1:0], {(DVD_W-SIN_W){1'b0}}};
    assign div_divisor = (state_reg == ST_IDLE) ? hp_eff : DVR_W'(n_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ang_next = ang_reg;
        n_next = n_reg;
        t_next = t_reg;
        t2_next = t2_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        wave_value_next = wave_value_reg;
        op_a = t_reg;
        op_b = t_reg;
        div_req.start = 1'b0;
        div_req.steps = PHASE_STEPS;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_req.start = 1'b1;
                    div_req.steps = PHASE_STEPS;
                    acc_next = '0;
                    n_next = N_W'(1);
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                if (div_done)
                begin
                    phase_next = div_quo[PHASE_W-1:0];
                    ang_next = div_quo[PHASE_W-1:0];
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (n_reg > order)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    t_next = quad[0] ? (Q30_ONE - r_ext) : r_ext;
                    neg_next = quad[1];
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                op_a = t_reg;
                op_b = t_reg;
                prod_next = mul_res;
                state_next = ST_P9;
            end
            ST_P9:
            begin
                op_a = prod_q30;
                op_b = COEF_A9;
                t2_next = prod_q30;
                prod_next = mul_res;
                state_next = ST_P7;
            end
            ST_P7:
            begin
                op_a = t2_reg;
                op_b = COEF_A7 - prod_q30;
                prod_next = mul_res;
                state_next = ST_P5;
            end
            ST_P5:
            begin
                op_a = t2_reg;
                op_b = COEF_A5 - prod_q30;
                prod_next = mul_res;
                state_next = ST_P3;
            end
            ST_P3:
            begin
                op_a = t2_reg;
                op_b = COEF_A3 - prod_q30;
                prod_next = mul_res;
                state_next = ST_P1;
            end
            ST_P1:
            begin
                op_a = t_reg;
                op_b = COEF_A1 - prod_q30;
                prod_next = mul_res;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = TERM_STEPS;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    acc_next = neg_reg ? (acc_reg - signed'(quo_ext))
                                       : (acc_reg + signed'(quo_ext));
                    ang_next = ang_reg + {phase_reg[PHASE_W-2:0], 1'b0};
                    n_next = n_reg + N_W'(2);
                    state_next = ST_TERM;
                end
            end
            ST_SCALE:
            begin
                op_a = acc_mag[MUL_W-1:0];
                op_b = K4PI;
                prod_next = mul_res;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    wave_value_next = (q14 > NEG_LIMIT) ? SAT_NEG : OUT_W'(-q14[OUT_W-1:0]);
                end
                else
                begin
                    wave_value_next = (q14 > POS_LIMIT) ? SAT_POS : q14[OUT_W-1:0];
                end
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg <= N_W'(1);
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        ang_reg <= ang_next;
        t_reg <= t_next;
        t2_reg <= t2_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        prod_reg <= prod_next;
        wave_value_reg <= wave_value_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign wave_value = signed'(wave_value_reg);

    // The sequencer and divider must agree on when a quotient is ready.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_PHASE || state_reg == ST_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == ST_PHASE))
        else $error("accepted beat did not start the phase division");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(state_reg) == ST_ROUND))
        else $error("result beat not issued from the rounding step");

    a_harmonic_odd: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg[0])
        else $error("harmonic index became even");

endmodule
